>>> rtl/psvm_pkg.sv
package psvm_pkg;

    localparam int VOICES         = 13;
    localparam int PHASE_BITS     = 24;
    localparam int SINE_ADDR_BITS = 10;
    localparam int AMP_BITS       = 16;
    localparam int KEY_BITS       = 13;
    localparam int OUT_BITS       = 20;
    localparam int BASE_NOTES     = 13;

    localparam int VIDX_BITS    = (VOICES > 1) ? $clog2(VOICES) : 1;
    localparam int QUARTER_BITS = SINE_ADDR_BITS - 2;
    localparam int QUARTER_LEN  = 1 << QUARTER_BITS;

    localparam longint AMPMAX      = (longint'(1) << (AMP_BITS - 1)) - 1;
    localparam longint ONE_Q30     = longint'(1) << 30;
    localparam longint HALF_PI_Q30 = 64'sd1686629713;

    localparam longint BASE_WORDS [BASE_NOTES] = '{
        99526, 105449, 111707, 118365, 125403, 132860, 140468,
        149131, 157995, 167584, 177344, 187890, 199063
    };

    typedef logic [PHASE_BITS-1:0] tuning_tab_t [VOICES];
    typedef logic [AMP_BITS-1:0]   sine_tab_t [QUARTER_LEN];

    typedef struct packed {
        logic                      valid;
        logic                      active;
        logic                      last;
        logic [SINE_ADDR_BITS-1:0] addr;
    } lookup_req_t;

    typedef struct packed {
        logic                       valid;
        logic                       last;
        logic signed [AMP_BITS-1:0] amp;
    } amp_res_t;

    function automatic logic [PHASE_BITS-1:0] scale_word(input longint w24);
        longint sh;
        longint res;
        if (PHASE_BITS >= 24)
        begin
            sh  = PHASE_BITS - 24;
            res = w24 << sh;
        end
        else
        begin
            sh  = 24 - PHASE_BITS;
            res = (w24 + (longint'(1) << (sh - 1))) >> sh;
        end
        return res[PHASE_BITS-1:0];
    endfunction

    function automatic tuning_tab_t build_tuning();
        tuning_tab_t tab;
        longint      w;
        for (int i = 0; i < VOICES; i++)
        begin
            if (i < BASE_NOTES)
                w = BASE_WORDS[i];
            else
                w = BASE_WORDS[i % 12] << (i / 12);
            tab[i] = scale_word(w);
        end
        return tab;
    endfunction

    // The quarter-wave entries come from a Q30 Taylor series of nine terms.
    function automatic longint sine_entry(input longint k);
        longint x;
        longint x2;
        longint term;
        longint sum;
        x    = (HALF_PI_Q30 * k + longint'(QUARTER_LEN >> 1)) >>> QUARTER_BITS;
        x2   = (x * x) >>> 30;
        term = x;
        sum  = x;
        term = -(term * x2) / (6 * ONE_Q30);
        sum  = sum + term;
        term = -(term * x2) / (20 * ONE_Q30);
        sum  = sum + term;
        term = -(term * x2) / (42 * ONE_Q30);
        sum  = sum + term;
        term = -(term * x2) / (72 * ONE_Q30);
        sum  = sum + term;
        term = -(term * x2) / (110 * ONE_Q30);
        sum  = sum + term;
        term = -(term * x2) / (156 * ONE_Q30);
        sum  = sum + term;
        term = -(term * x2) / (210 * ONE_Q30);
        sum  = sum + term;
        term = -(term * x2) / (272 * ONE_Q30);
        sum  = sum + term;
        if (sum < 0)
            sum = 0;
        if (sum > ONE_Q30)
            sum = ONE_Q30;
        return (sum * AMPMAX + (longint'(1) << 29)) >>> 30;
    endfunction

    function automatic sine_tab_t build_sine();
        sine_tab_t tab;
        longint    v;
        for (int k = 0; k < QUARTER_LEN; k++)
        begin
            v      = sine_entry(longint'(k));
            tab[k] = v[AMP_BITS-1:0];
        end
        return tab;
    endfunction

    localparam tuning_tab_t TUNING     = build_tuning();
    localparam sine_tab_t   SINE_TABLE = build_sine();
    localparam longint      PEAK_LONG  = sine_entry(longint'(QUARTER_LEN));
    localparam logic [AMP_BITS-1:0] SINE_PEAK = PEAK_LONG[AMP_BITS-1:0];

endpackage

>>> rtl/psvm_sine_lookup.sv
module psvm_sine_lookup (
    input  logic                  clk,
    input  logic                  rst_n,
    input  psvm_pkg::lookup_req_t req,
    output psvm_pkg::amp_res_t    res
);

    logic [1:0]                          quad;
    logic [psvm_pkg::QUARTER_BITS-1:0]   k;
    logic [psvm_pkg::QUARTER_BITS-1:0]   k_mirror;
    logic [psvm_pkg::AMP_BITS-1:0]       mag;
    logic signed [psvm_pkg::AMP_BITS-1:0] amp_next;
    logic                                 valid_reg;
    logic                                 last_reg;
    logic signed [psvm_pkg::AMP_BITS-1:0] amp_reg;

    assign quad     = req.addr[psvm_pkg::SINE_ADDR_BITS-1 -: 2];
    assign k        = req.addr[psvm_pkg::QUARTER_BITS-1:0];
    assign k_mirror = ~k + psvm_pkg::QUARTER_BITS'(1);

    always_comb
    begin
        if (!quad[0])
            mag = psvm_pkg::SINE_TABLE[k];
        else if (k == '0)
            mag = psvm_pkg::SINE_PEAK;
        else
            mag = psvm_pkg::SINE_TABLE[k_mirror];
        if (!req.active)
            amp_next = '0;
        else if (quad[1])
            amp_next = -$signed(mag);
        else
            amp_next = $signed(mag);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            last_reg  <= 1'b0;
        end
        else
        begin
            valid_reg <= req.valid;
            last_reg  <= req.valid && req.last;
        end
    end

    always_ff @(posedge clk)
    begin
        amp_reg <= amp_next;
    end

    assign res.valid = valid_reg;
    assign res.last  = last_reg;
    assign res.amp   = amp_reg;

endmodule

>>> rtl/polyphonic_sine_voice_mixer.sv
// Each accepted item is one sample tick; the block steps every sounding voice's phase and
// returns one summed sample per item, and it takes no new item while it is still working on
// the last one. Each item passes through the phase memory, which is read and written back one
// voice per cycle, followed by a registered sine lookup and the accumulate. A new item is
// taken once the previous sum has moved to the output register, so a result may wait there
// while the next tick is already being worked on.
module polyphonic_sine_voice_mixer (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 key_valid,
    output logic                                 key_stall,
    input  logic [psvm_pkg::KEY_BITS-1:0]        key_mask,
    output logic                                 sample_valid,
    input  logic                                 sample_stall,
    output logic signed [psvm_pkg::OUT_BITS-1:0] sample_value
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_DRAIN,
        ST_HOLD
    } state_t;

    localparam logic [psvm_pkg::VIDX_BITS-1:0] LAST_VOICE =
        psvm_pkg::VIDX_BITS'(psvm_pkg::VOICES - 1);

    state_t                                state_reg;
    logic [psvm_pkg::VIDX_BITS-1:0]        cnt_reg;
    logic [psvm_pkg::VOICES-1:0]           mask_reg;
    logic [psvm_pkg::PHASE_BITS-1:0]       phase_mem [psvm_pkg::VOICES];
    logic [psvm_pkg::VOICES-1:0]           phase_ok_reg;
    logic [psvm_pkg::PHASE_BITS-1:0]       rd_data_reg;
    logic                                  m_valid_reg;
    logic [psvm_pkg::VIDX_BITS-1:0]        m_idx_reg;
    logic signed [psvm_pkg::OUT_BITS-1:0]  sum_reg;
    logic signed [psvm_pkg::OUT_BITS-1:0]  hold_reg;
    logic signed [psvm_pkg::OUT_BITS-1:0]  total;
    logic                                  sample_valid_reg;
    logic signed [psvm_pkg::OUT_BITS-1:0]  sample_value_reg;

    logic                                  rd_en;
    logic                                  active;
    logic                                  wr_en;
    logic [psvm_pkg::PHASE_BITS-1:0]       new_phase;
    logic                                  out_free;
    logic                                  out_load;
    logic                                  accept;
    psvm_pkg::lookup_req_t                 req;
    psvm_pkg::amp_res_t                    res;

    assign accept    = key_valid && !key_stall;
    assign key_stall = state_reg != ST_IDLE;
    assign rd_en     = state_reg == ST_ISSUE;
    assign active    = mask_reg[m_idx_reg];
    assign wr_en     = m_valid_reg && active;
    assign new_phase = rd_data_reg + psvm_pkg::TUNING[m_idx_reg];
    assign total     = sum_reg + psvm_pkg::OUT_BITS'(res.amp);
    assign out_free  = !sample_valid_reg || !sample_stall;
    assign out_load  = out_free && (state_reg == ST_HOLD ||
                       (state_reg == ST_DRAIN && res.valid && res.last));

    assign req.valid  = m_valid_reg;
    assign req.active = active;
    assign req.last   = m_idx_reg == LAST_VOICE;
    assign req.addr   = new_phase[psvm_pkg::PHASE_BITS-1 -: psvm_pkg::SINE_ADDR_BITS];

    psvm_sine_lookup u_lookup (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .res   (res)
    );

    // Entries not yet written read as zero phase.
    always_ff @(posedge clk)
    begin
        if (rd_en)
            rd_data_reg <= phase_ok_reg[cnt_reg] ? phase_mem[cnt_reg] : '0;
        if (wr_en)
            phase_mem[m_idx_reg] <= new_phase;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_ok_reg <= '0;
            m_valid_reg  <= 1'b0;
        end
        else
        begin
            if (wr_en)
                phase_ok_reg[m_idx_reg] <= 1'b1;
            m_valid_reg <= rd_en;
        end
    end

    always_ff @(posedge clk)
    begin
        m_idx_reg <= cnt_reg;
        if (accept)
            mask_reg <= psvm_pkg::VOICES'(key_mask);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            cnt_reg          <= '0;
            sum_reg          <= '0;
            hold_reg         <= '0;
            sample_valid_reg <= 1'b0;
            sample_value_reg <= '0;
        end
        else
        begin
            if (out_load)
                sample_valid_reg <= 1'b1;
            else if (!sample_stall)
                sample_valid_reg <= 1'b0;
            if (res.valid)
                sum_reg <= total;
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (key_valid)
                    begin
                        cnt_reg   <= '0;
                        sum_reg   <= '0;
                        state_reg <= ST_ISSUE;
                    end
                end
                ST_ISSUE:
                begin
                    if (cnt_reg == LAST_VOICE)
                        state_reg <= ST_DRAIN;
                    else
                        cnt_reg <= cnt_reg + psvm_pkg::VIDX_BITS'(1);
                end
                ST_DRAIN:
                begin
                    if (res.valid && res.last)
                    begin
                        if (out_free)
                        begin
                            sample_value_reg <= total;
                            state_reg        <= ST_IDLE;
                        end
                        else
                        begin
                            hold_reg  <= total;
                            state_reg <= ST_HOLD;
                        end
                    end
                end
                ST_HOLD:
                begin
                    if (out_free)
                    begin
                        sample_value_reg <= hold_reg;
                        state_reg        <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign sample_valid = sample_valid_reg;
    assign sample_value = sample_value_reg;

    a_accept_starts_run: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg == ST_ISSUE && cnt_reg == '0)
        else $error("accepted item did not start a voice sweep at voice zero");

    a_write_only_sounding: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> mask_reg[m_idx_reg] && state_reg != ST_IDLE)
        else $error("phase written for a voice that is not sounding");

    a_last_amp_in_drain: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && res.last |-> state_reg == ST_DRAIN)
        else $error("final voice amplitude arrived outside the drain phase");

    a_hold_means_busy_output: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_HOLD |-> sample_valid_reg)
        else $error("sum held back although the output register is empty");

endmodule
